[hdl/bvf_pkg.sv]
// ----------------------------------------------------------------------------
// bvf_pkg
// Shared widths, constants and unit request and response types of the battery
// voltage filter.
// ----------------------------------------------------------------------------
package bvf_pkg;

   localparam int CODE_W      = 12;
   localparam int MV_W        = 16;
   localparam int CNT_OUT_W   = 5;
   localparam int Q8_W        = 24;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam int DIV_W   = 24;
   localparam int DVSR_W  = 12;
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [DVSR_W-1:0] CODE_FULL = 12'd4095;
   localparam logic [Q8_W-1:0]   SAT_Q8    = 24'hFFFF00;

   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_SCALE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVIDER    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIM       = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTHING  = 4'd3;

   localparam logic [CODE_W-1:0]     RST_FULL_SCALE = 12'd3100;
   localparam logic [CSR_DATA_W-1:0] RST_DIVIDER    = 16'd4096;
   localparam logic [CSR_DATA_W-1:0] RST_TRIM       = 16'd16384;
   localparam logic [CSR_DATA_W-1:0] RST_SMOOTHING  = 16'd13107;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

[hdl/bvf_div.sv]
// ----------------------------------------------------------------------------
// bvf_div
// Restoring divider, one quotient bit per cycle, pulses done when the
// quotient is ready.
// ----------------------------------------------------------------------------
module bvf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bvf_pkg::div_req_type req,
   output bvf_pkg::div_rsp_type rsp
);
   import bvf_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   trial_sub;
   logic              fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_W-1]};
      fits      = trial >= {1'b0, dvsr_ff};
      trial_sub = trial - {1'b0, dvsr_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvsr_in   = dvsr_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvsr_in = req.divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[hdl/bvf_mul.sv]
// ----------------------------------------------------------------------------
// bvf_mul
// Shared unsigned multiplier with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module bvf_mul (
   input  logic                          clock,
   input  bvf_pkg::mul_req_type          req,
   output logic [bvf_pkg::MUL_P_W-1:0]   product
);
   import bvf_pkg::*;

   logic [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
      end
   end

   assign product = prod_ff;

endmodule

[hdl/battery_voltage_filter_top.sv]
// ----------------------------------------------------------------------------
// battery_voltage_filter_top
// Burst mean of converter reads, scaling to millivolts and exponential
// smoothing.
// ----------------------------------------------------------------------------
// Reads are accepted while the block is idle. After the last read of a burst that
// had at least one good read, req_tready stays low while one divider and one
// shared multiplier run the sequence: the 24-bit restoring divider forms the
// mean, and the division by 4095 is a shift-add estimate with one correction
// step. A burst without good reads gives no result and the block stays idle.
// The result waits in an output register; if it is still not taken when the
// next burst finishes, the block holds until it is.
module battery_voltage_filter_top #(
   parameter int READS_PER_BURST = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // raw_code [11:0]
   input  logic [0:0]  req_tuser,   // read_good [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // filtered_mv [15:0], burst_mv [31:16], good_reads [36:32]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [bvf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bvf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bvf_pkg::*;

   localparam int POS_W       = $clog2(READS_PER_BURST + 1);
   localparam int CNT_W       = $clog2(READS_PER_BURST + 1);
   localparam int SUM_W       = CODE_W + $clog2(READS_PER_BURST + 1);
   localparam int SCALE_SHIFT = 18;
   localparam int ALPHA_SHIFT = 16;
   localparam int SCALED_W    = MUL_P_W - SCALE_SHIFT;
   localparam int RSP_W       = 40;
   localparam int RSP_PAD     = RSP_W - 2 * MV_W - CNT_OUT_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_MEAN,
      S_WAIT_MEAN,
      S_MUL_FS,
      S_EST_MV,
      S_FIX_MV,
      S_MUL_DIV,
      S_MUL_TRIM,
      S_SAT,
      S_MUL_ALPHA,
      S_FILT
   } state_type;

   state_type state_ff, state_in;

   logic [CODE_W-1:0]     fs_ff, fs_in;
   logic [CSR_DATA_W-1:0] div_ff, div_in;
   logic [CSR_DATA_W-1:0] trim_ff, trim_in;
   logic [CSR_DATA_W-1:0] alpha_ff, alpha_in;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [Q8_W-1:0]   smooth_ff, smooth_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [SUM_W-1:0]  bsum_ff, bsum_in;
   logic [CNT_W-1:0]  bcnt_ff, bcnt_in;
   logic [CODE_W-1:0] mean_ff, mean_in;
   logic [CODE_W-1:0] mv_ff, mv_in;
   logic [Q8_W-1:0]   v_ff, v_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [CODE_W-1:0]   raw;
   logic                good;
   logic                req_fire;
   logic                burst_last;
   logic [SUM_W-1:0]    sum_next;
   logic [CNT_W-1:0]    cnt_next;
   logic                out_free;
   logic [DIV_W-1:0]    mv_est_sum;
   logic [DIV_W-1:0]    mv_rem;
   logic                mv_fix;
   logic [SCALED_W-1:0] scaled;
   logic                v_ge;
   logic [Q8_W-1:0]     diff;
   logic [Q8_W-1:0]     step;
   logic [Q8_W-1:0]     filt_next;

   div_req_type          div_req;
   div_rsp_type          div_rsp;
   mul_req_type          mul_req;
   logic [MUL_P_W-1:0]   product;

   bvf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   bvf_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .product (product)
   );

   assign raw        = req_tdata[CODE_W-1:0];
   assign good       = req_tuser[0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      sum_next   = sum_ff + (good ? SUM_W'(raw) : SUM_W'(0));
      cnt_next   = cnt_ff + CNT_W'(good);
      burst_last = (pos_ff == POS_W'(READS_PER_BURST - 1));
      out_free   = !rsp_valid_ff || rsp_tready;
      // x/4095 estimate (x + x/4096)/4096, low by at most one
      mv_est_sum = product[DIV_W-1:0] + DIV_W'(product[DIV_W-1:CODE_W]);
      mv_rem     = product[DIV_W-1:0] - {mv_ff, CODE_W'(0)} + DIV_W'(mv_ff);
      mv_fix     = mv_rem >= DIV_W'(CODE_FULL);
      scaled     = product[MUL_P_W-1:SCALE_SHIFT];
      v_ge       = v_ff >= smooth_ff;
      diff       = v_ge ? (v_ff - smooth_ff) : (smooth_ff - v_ff);
      step       = product[ALPHA_SHIFT +: Q8_W];
      if (smooth_ff == '0) begin
         filt_next = v_ff;
      end else if (v_ge) begin
         filt_next = smooth_ff + step;
      end else begin
         filt_next = smooth_ff - step;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fs_in        = fs_ff;
      div_in       = div_ff;
      trim_in      = trim_ff;
      alpha_in     = alpha_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      smooth_in    = smooth_ff;
      rsp_valid_in = rsp_valid_ff;
      bsum_in      = bsum_ff;
      bcnt_in      = bcnt_ff;
      mean_in      = mean_ff;
      mv_in        = mv_ff;
      v_in         = v_ff;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      mul_req      = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FULL_SCALE: fs_in    = csr_data[CODE_W-1:0];
            CSR_DIVIDER:    div_in   = csr_data;
            CSR_TRIM:       trim_in  = csr_data;
            CSR_SMOOTHING:  alpha_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (burst_last) begin
                  sum_in  = '0;
                  cnt_in  = '0;
                  pos_in  = '0;
                  bsum_in = sum_next;
                  bcnt_in = cnt_next;
                  if (cnt_next != '0) begin
                     state_in = S_DIV_MEAN;
                  end
               end else begin
                  sum_in = sum_next;
                  cnt_in = cnt_next;
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         S_DIV_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(bsum_ff);
            div_req.divisor  = DVSR_W'(bcnt_ff);
            state_in         = S_WAIT_MEAN;
         end
         S_WAIT_MEAN: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quotient[CODE_W-1:0];
               state_in = S_MUL_FS;
            end
         end
         S_MUL_FS: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(mean_ff);
            mul_req.b  = MUL_B_W'(fs_ff);
            state_in   = S_EST_MV;
         end
         S_EST_MV: begin
            mv_in    = mv_est_sum[DIV_W-1:CODE_W];
            state_in = S_FIX_MV;
         end
         S_FIX_MV: begin
            mv_in    = mv_ff + CODE_W'(mv_fix);
            state_in = S_MUL_DIV;
         end
         S_MUL_DIV: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(mv_ff);
            mul_req.b  = div_ff;
            state_in   = S_MUL_TRIM;
         end
         S_MUL_TRIM: begin
            mul_req.en = 1'b1;
            mul_req.a  = product[MUL_A_W-1:0];
            mul_req.b  = trim_ff;
            state_in   = S_SAT;
         end
         S_SAT: begin
            v_in     = (scaled > SCALED_W'(SAT_Q8)) ? SAT_Q8 : scaled[Q8_W-1:0];
            state_in = S_MUL_ALPHA;
         end
         S_MUL_ALPHA: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(diff);
            mul_req.b  = alpha_ff;
            state_in   = S_FILT;
         end
         S_FILT: begin
            if (out_free) begin
               smooth_in    = filt_next;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD'(0), CNT_OUT_W'(bcnt_ff),
                               v_ff[Q8_W-1:Q8_W-MV_W], filt_next[Q8_W-1:Q8_W-MV_W]};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      bsum_ff     <= bsum_in;
      bcnt_ff     <= bcnt_in;
      mean_ff     <= mean_in;
      mv_ff       <= mv_in;
      v_ff        <= v_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         fs_ff        <= RST_FULL_SCALE;
         div_ff       <= RST_DIVIDER;
         trim_ff      <= RST_TRIM;
         alpha_ff     <= RST_SMOOTHING;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fs_ff        <= fs_in;
         div_ff       <= div_in;
         trim_ff      <= trim_in;
         alpha_ff     <= alpha_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hdl/bvf_checker.sv]
// ----------------------------------------------------------------------------
// bvf_checker
// Port-level checks of the battery voltage filter, bound to the top level.
// ----------------------------------------------------------------------------
module bvf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a transfer while idle empties the output register
   a_one_shot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && req_tready |=> !rsp_tvalid)
      else $error("result repeated after transfer");

   // a new result comes only from the busy sequence
   a_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while idle");

endmodule

bind battery_voltage_filter_top bvf_checker u_checker (.*);
